/* sv/q2e_pkg.sv */
// Shared types, constants and the arctangent table of the quaternion to Euler unit.
package q2e_pkg;

	localparam int SUM_W = 35;
	localparam int CRD_W = 40;
	localparam int ANG_W = 35;
	localparam int SQ_BITS = 29;
	localparam int REM_W = 57;
	localparam int ROOT_ACC_W = 58;

	localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(64'sd268435456);
	localparam logic signed [ANG_W-1:0] PI_Q30 = ANG_W'(64'sd3373259426);
	localparam logic [15:0] HALF_PI_Q13 = 16'd12868;
	localparam logic [15:0] PI_Q13 = 16'd25736;

	localparam logic [30:0] ATAN_HEAD [0:10] = '{
		31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
		31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149, 31'd1048575
	};

	typedef struct packed {
		logic signed [SUM_W-1:0] sr;
		logic signed [SUM_W-1:0] cr;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] cy;
		logic signed [SUM_W-1:0] sp;
		logic                    sat;
	} q2e_sums_t;

	// floor(atan(2^-i) * 2^30)
	function automatic logic [30:0] atan_q30(input int unsigned i);
		logic [31:0] one;
		one = 32'd1;
		if (i <= 10) begin
			return ATAN_HEAD[i];
		end else if (i <= 30) begin
			return 31'((one << (30 - i)) - one);
		end else begin
			return 31'd0;
		end
	endfunction

endpackage

/* sv/q2e_if.sv */
// Valid/ready channel interfaces for quaternion input and angle output.
interface q2e_quat_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic               pitch_saturated;
	modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
		input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
		output ready);
endinterface

/* sv/quaternion_to_euler_unit.sv */
// Top level: quaternion (Q2.14) to roll, pitch, yaw (Q3.13) conversion pipeline.
// Throughput: one transfer per cycle; the whole pipeline advances whenever the output
// register is empty or its result is taken, so it holds only while the output stalls.
// Reset (arst_n low, asynchronous) clears every valid bit; data registers are not reset.
// Stages: 5 product/sum stages, 29 square-root bit stages, then three CORDIC lanes.
module quaternion_to_euler_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	q2e_quat_if.sink      sample,
	q2e_euler_if.source   angles
);
	localparam int LAT_C = CORDIC_STEPS + 2;

	logic                            en;
	logic                            pv;
	q2e_pkg::q2e_sums_t              psums;
	logic [q2e_pkg::REM_W-1:0]       prem;
	logic                            qv;
	logic [q2e_pkg::SQ_BITS-1:0]     qroot;
	logic [$bits(q2e_pkg::q2e_sums_t)-1:0] qside;
	q2e_pkg::q2e_sums_t              qsums;
	logic                            v_roll, v_pitch, v_yaw;
	logic signed [15:0]              roll, pitch, yaw;
	logic                            sat_s [0:LAT_C];
	logic                            neg_s [0:LAT_C];

	// whole pipeline moves together; the output register is the last stage
	assign en           = !angles.valid || angles.ready;
	assign sample.ready = en;

	q2e_prod u_prod (
		.clk, .arst_n, .en,
		.vin  (sample.valid),
		.w    (sample.quat_w),
		.x    (sample.quat_x),
		.y    (sample.quat_y),
		.z    (sample.quat_z),
		.vout (pv),
		.sums (psums),
		.rem  (prem)
	);

	// sqrt of 1 - s^2 for the pitch cosine; other sums ride along
	q2e_sqrt #(.SIDE_W($bits(q2e_pkg::q2e_sums_t))) u_sqrt (
		.clk, .arst_n, .en,
		.vin      (pv),
		.rad      (prem),
		.side_in  (psums),
		.vout     (qv),
		.root     (qroot),
		.side_out (qside)
	);

	assign qsums = qside;

	q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(q2e_pkg::PI_Q13)) u_roll (
		.clk, .arst_n, .en,
		.vin   (qv),
		.yi    (q2e_pkg::CRD_W'(qsums.sr)),
		.xi    (q2e_pkg::CRD_W'(qsums.cr)),
		.vout  (v_roll),
		.angle (roll)
	);

	q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(q2e_pkg::HALF_PI_Q13)) u_pitch (
		.clk, .arst_n, .en,
		.vin   (qv),
		.yi    (q2e_pkg::CRD_W'(qsums.sp)),
		.xi    ($signed(q2e_pkg::CRD_W'(qroot))),
		.vout  (v_pitch),
		.angle (pitch)
	);

	q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(q2e_pkg::PI_Q13)) u_yaw (
		.clk, .arst_n, .en,
		.vin   (qv),
		.yi    (q2e_pkg::CRD_W'(qsums.sy)),
		.xi    (q2e_pkg::CRD_W'(qsums.cy)),
		.vout  (v_yaw),
		.angle (yaw)
	);

	// clamp flag and sine sign follow the CORDIC lanes
	assign sat_s[0] = qsums.sat;
	assign neg_s[0] = qsums.sp[q2e_pkg::SUM_W-1];

	for (genvar k = 0; k < LAT_C; k++) begin : g_flag
		always_ff @(posedge clk) begin
			if (en) begin
				sat_s[k+1] <= sat_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign angles.valid           = v_roll;
	assign angles.roll_angle      = roll;
	assign angles.yaw_angle       = yaw;
	assign angles.pitch_saturated = sat_s[LAT_C];
	assign angles.pitch_angle     = sat_s[LAT_C]
		? (neg_s[LAT_C] ? -$signed(q2e_pkg::HALF_PI_Q13[14:0])
		                : $signed(q2e_pkg::HALF_PI_Q13[14:0]))
		: pitch[14:0];

	// three lanes share one enable, so their valids never part
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(v_roll == v_pitch) && (v_roll == v_yaw))
		else $error("cordic lanes out of step");

	// input is held back only by a result waiting at the output
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (angles.valid && !angles.ready))
		else $error("input stalled without output stall");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid |-> ($signed(angles.roll_angle) <= 16'sd25736 &&
		                  $signed(angles.roll_angle) >= -16'sd25736))
		else $error("roll out of range");

	a_sat_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		(angles.valid && angles.pitch_saturated) |->
		(angles.pitch_angle == 15'sd12868 || angles.pitch_angle == -15'sd12868))
		else $error("clamped pitch not at half pi");
endmodule

/* sv/q2e_prod.sv */
// Front end: products, sums of products, pitch sine magnitude and sqrt operand.
module q2e_prod (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vin,
	input  logic signed [15:0]              w,
	input  logic signed [15:0]              x,
	input  logic signed [15:0]              y,
	input  logic signed [15:0]              z,
	output logic                            vout,
	output q2e_pkg::q2e_sums_t              sums,
	output logic [q2e_pkg::REM_W-1:0]       rem
);
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	q2e_pkg::q2e_sums_t sums_s2, sums_s3, sums_s4, sums_s5;
	q2e_pkg::q2e_sums_t sums_n, sums_c;
	logic [27:0] mag_s3;
	logic [55:0] sq_s4;
	logic [q2e_pkg::REM_W-1:0] rem_s5;
	logic signed [q2e_pkg::SUM_W-1:0] mag_c;

	function automatic logic signed [q2e_pkg::SUM_W-1:0] ext(input logic signed [31:0] p);
		return {{(q2e_pkg::SUM_W-32){p[31]}}, p};
	endfunction

	always_comb begin
		sums_n.sr  = (ext(wx_s1) + ext(yz_s1)) <<< 1;
		sums_n.cr  = q2e_pkg::ONE_Q28 - ((ext(xx_s1) + ext(yy_s1)) <<< 1);
		sums_n.sp  = (ext(wy_s1) - ext(zx_s1)) <<< 1;
		sums_n.sy  = (ext(wz_s1) + ext(xy_s1)) <<< 1;
		sums_n.cy  = q2e_pkg::ONE_Q28 - ((ext(yy_s1) + ext(zz_s1)) <<< 1);
		sums_n.sat = 1'b0;

		mag_c = sums_s2.sp[q2e_pkg::SUM_W-1] ? -sums_s2.sp : sums_s2.sp;

		sums_c     = sums_s2;
		sums_c.sat = (mag_c >= q2e_pkg::ONE_Q28);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= w * x;
			yz_s1 <= y * z;
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			wy_s1 <= w * y;
			zx_s1 <= z * x;
			wz_s1 <= w * z;
			xy_s1 <= x * y;
			zz_s1 <= z * z;

			sums_s2 <= sums_n;

			sums_s3 <= sums_c;
			mag_s3  <= mag_c[27:0];

			sums_s4 <= sums_s3;
			sq_s4   <= 56'(mag_s3) * 56'(mag_s3);

			sums_s5 <= sums_s4;
			rem_s5  <= (q2e_pkg::REM_W'(1) << 56) - q2e_pkg::REM_W'(sq_s4);
		end
	end

	assign vout = v_s5;
	assign sums = sums_s5;
	assign rem  = rem_s5;
endmodule

/* sv/q2e_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with a sideband.
module q2e_sqrt #(
	parameter int SIDE_W = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vin,
	input  logic [q2e_pkg::REM_W-1:0]       rad,
	input  logic [SIDE_W-1:0]               side_in,
	output logic                            vout,
	output logic [q2e_pkg::SQ_BITS-1:0]     root,
	output logic [SIDE_W-1:0]               side_out
);
	localparam int N = q2e_pkg::SQ_BITS;
	localparam int AW = q2e_pkg::ROOT_ACC_W;

	logic [AW-1:0]     rem_s [0:N];
	logic [AW-1:0]     res_s [0:N];
	logic              v_s   [0:N];
	logic [SIDE_W-1:0] side_s [0:N];

	assign rem_s[0]  = AW'(rad);
	assign res_s[0]  = '0;
	assign v_s[0]    = vin;
	assign side_s[0] = side_in;

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam logic [AW-1:0] BIT = AW'(1) << (2 * (N - 1 - j));
		logic [AW-1:0] trial;
		logic          take;
		assign trial = res_s[j] + BIT;
		assign take  = rem_s[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= take ? rem_s[j] - trial : rem_s[j];
				res_s[j+1]  <= take ? (res_s[j] >> 1) + BIT : res_s[j] >> 1;
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign vout     = v_s[N];
	assign root     = res_s[N][N-1:0];
	assign side_out = side_s[N];
endmodule

/* sv/q2e_cordic.sv */
// Pipelined vectoring CORDIC: four-quadrant atan2, rounded and clamped to Q3.13.
module q2e_cordic #(
	parameter int STEPS = 16,
	parameter logic [15:0] LIM = 16'd25736
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vin,
	input  logic signed [q2e_pkg::CRD_W-1:0] yi,
	input  logic signed [q2e_pkg::CRD_W-1:0] xi,
	output logic                            vout,
	output logic signed [15:0]              angle
);
	localparam int CW = q2e_pkg::CRD_W;
	localparam int ZW = q2e_pkg::ANG_W;

	logic signed [CW-1:0] x_s [0:STEPS];
	logic signed [CW-1:0] y_s [0:STEPS];
	logic signed [ZW-1:0] z_s [0:STEPS];
	logic                 v_s [0:STEPS];
	logic                 zero_s [0:STEPS];
	logic                 v_q;
	logic signed [15:0]   angle_q;
	logic signed [ZW-1:0] zr;
	logic signed [ZW-18:0] r;

	// quadrant fold: a negative cosine is turned by pi first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (xi == '0) && (yi == '0);
			if (xi[CW-1]) begin
				x_s[0] <= -xi;
				y_s[0] <= -yi;
				z_s[0] <= yi[CW-1] ? -q2e_pkg::PI_Q30 : q2e_pkg::PI_Q30;
			end else begin
				x_s[0] <= xi;
				y_s[0] <= yi;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ATN = ZW'(q2e_pkg::atan_q30(i));
		logic signed [CW-1:0] xs, ys;
		logic                 pos;
		assign xs  = x_s[i] >>> i;
		assign ys  = y_s[i] >>> i;
		assign pos = !y_s[i][CW-1] && (y_s[i] != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (pos) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + ATN;
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - ATN;
				end
			end
		end
	end

	assign zr = z_s[STEPS] + ZW'(65536);
	assign r  = zr[ZW-1:17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[STEPS]) begin
				angle_q <= '0;
			end else if (r > $signed({2'b00, LIM})) begin
				angle_q <= $signed(LIM);
			end else if (r < -$signed({2'b00, LIM})) begin
				angle_q <= -$signed(LIM);
			end else begin
				angle_q <= r[15:0];
			end
		end
	end

	assign vout  = v_q;
	assign angle = angle_q;
endmodule
